/* rtl/snwt_pkg.sv */
// Shared types, constants and the token decode function for the Spanish number word block.
`default_nettype none

package snwt_pkg;

    // Payload widths.
    localparam int VALUE_W  = 30;
    localparam int CLASS_W  = 4;
    localparam int DIGIT_W  = 4;

    // Largest number that can be spelled; larger inputs saturate to it.
    localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd999999999;

    // Binary to decimal conversion: nine BCD digits beside the binary word.
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int SR_W       = BCD_W + VALUE_W;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int STEP_NUM   = 6;

    // Word classes.
    localparam logic [CLASS_W-1:0] CL_CERO     = 4'd0;
    localparam logic [CLASS_W-1:0] CL_UNIT     = 4'd1;
    localparam logic [CLASS_W-1:0] CL_UN       = 4'd2;
    localparam logic [CLASS_W-1:0] CL_TEEN     = 4'd3;
    localparam logic [CLASS_W-1:0] CL_DIECI    = 4'd4;
    localparam logic [CLASS_W-1:0] CL_TENS     = 4'd5;
    localparam logic [CLASS_W-1:0] CL_VEINTI   = 4'd6;
    localparam logic [CLASS_W-1:0] CL_Y        = 4'd7;
    localparam logic [CLASS_W-1:0] CL_CIEN     = 4'd8;
    localparam logic [CLASS_W-1:0] CL_CIENTO   = 4'd9;
    localparam logic [CLASS_W-1:0] CL_HUNDREDS = 4'd10;
    localparam logic [CLASS_W-1:0] CL_MIL      = 4'd11;
    localparam logic [CLASS_W-1:0] CL_MILLON   = 4'd12;
    localparam logic [CLASS_W-1:0] CL_MILLONES = 4'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_ZERO,
        ST_EMIT
    } t_state;

    // Three-digit groups, in spelling order.
    typedef enum logic [1:0] {
        G_MILL,
        G_THOU,
        G_UNIT
    } t_group;

    // Token slots within one group, in spelling order.
    typedef enum logic [2:0] {
        STEP_HUND,
        STEP_TENS,
        STEP_Y,
        STEP_UNIT,
        STEP_SUF1,
        STEP_SUF2
    } t_step;

    typedef struct packed {
        logic               valid;
        logic [CLASS_W-1:0] cls;
        logic [DIGIT_W-1:0] dig;
        logic               shortf;
    } t_token;

    function automatic t_token mk_tok(logic [CLASS_W-1:0] cls, logic [DIGIT_W-1:0] dig,
                                      logic shortf);
        t_token k;
        k.valid  = 1'b1;
        k.cls    = cls;
        k.dig    = dig;
        k.shortf = shortf;
        return k;
    endfunction

    // Token, if any, that slot s of group g produces for digits h, t, u.
    // The caller skips groups whose three digits are all zero.
    function automatic t_token tok_at(t_step s, t_group g, logic [3:0] h, logic [3:0] t,
                                      logic [3:0] u);
        t_token k;
        logic   suffix;
        logic   one;
        logic   low_zero;
        logic   compound;
        k        = '0;
        suffix   = (g != G_UNIT);
        one      = (h == 4'd0) && (t == 4'd0) && (u == 4'd1);
        low_zero = (t == 4'd0) && (u == 4'd0);
        compound = (t >= 4'd3) && (u != 4'd0);
        case (s)
            STEP_HUND: begin
                if (h == 4'd1) begin
                    k = mk_tok(low_zero ? CL_CIEN : CL_CIENTO, 4'd0, 1'b0);
                end else if (h != 4'd0) begin
                    k = mk_tok(CL_HUNDREDS, h, 1'b0);
                end
            end
            STEP_TENS: begin
                if (!low_zero) begin
                    if (t == 4'd0) begin
                        if (u == 4'd1 && suffix) begin
                            // A group of exactly one is carried by its suffix alone.
                            if (!one) begin
                                k = mk_tok(CL_UN, 4'd1, 1'b1);
                            end
                        end else begin
                            k = mk_tok(CL_UNIT, u, 1'b0);
                        end
                    end else if (u == 4'd0) begin
                        k = mk_tok(CL_TENS, t, 1'b0);
                    end else if (t == 4'd1) begin
                        k = mk_tok((u > 4'd5) ? CL_DIECI : CL_TEEN, u, 1'b0);
                    end else if (t == 4'd2) begin
                        k = mk_tok(CL_VEINTI, u, (u == 4'd1) && suffix);
                    end else begin
                        k = mk_tok(CL_TENS, t, 1'b0);
                    end
                end
            end
            STEP_Y: begin
                if (compound) begin
                    k = mk_tok(CL_Y, 4'd0, 1'b0);
                end
            end
            STEP_UNIT: begin
                if (compound) begin
                    if (u == 4'd1 && suffix) begin
                        k = mk_tok(CL_UN, 4'd1, 1'b1);
                    end else begin
                        k = mk_tok(CL_UNIT, u, 1'b0);
                    end
                end
            end
            STEP_SUF1: begin
                if (g == G_MILL) begin
                    k = one ? mk_tok(CL_UN, 4'd1, 1'b1) : mk_tok(CL_MILLONES, 4'd0, 1'b0);
                end else if (g == G_THOU) begin
                    k = mk_tok(CL_MIL, 4'd0, 1'b0);
                end
            end
            STEP_SUF2: begin
                if (g == G_MILL && one) begin
                    k = mk_tok(CL_MILLON, 4'd0, 1'b0);
                end
            end
            default: begin
                k = '0;
            end
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* rtl/snwt_ifs.sv */
// Valid/ready stream interfaces for the number input and the word token output.
`default_nettype none

interface snwt_in_if;
    logic                          valid;
    logic                          ready;
    logic [snwt_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface snwt_out_if;
    logic                          valid;
    logic                          ready;
    logic [snwt_pkg::CLASS_W-1:0]  word_class;
    logic [snwt_pkg::DIGIT_W-1:0]  digit;
    logic                          short_form;
    logic                          last;

    modport source (output valid, output word_class, output digit, output short_form,
                    output last, input ready);
    modport sink   (input valid, input word_class, input digit, input short_form,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/spanish_number_word_tokens_core.sv */
// Top level: spells a number of up to nine digits as a run of Spanish word tokens.
// Order: a nonzero number is first converted to BCD by shift-add-3 steps, then its groups
// and slots are walked, empty ones skipped, and each token goes through the output register;
// zero gives its single cero token through the output register.
// A new number is accepted only when the sequencer is idle, after every token of the last
// one has been loaded, and the walk waits while the sink stalls.
// Reset: synchronous, active low; it clears the sequencer and the output valid flag.
`default_nettype none

module spanish_number_word_tokens_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    snwt_in_if.sink           i_in,
    snwt_out_if.source        o_out
);

    // Sequencer state and the group/slot walk used while emitting tokens.
    snwt_pkg::t_state r_state, n_state;
    snwt_pkg::t_group r_grp;
    snwt_pkg::t_step  r_step;
    logic [snwt_pkg::CNT_W-1:0] r_cnt;

    // Combined BCD and binary shift register of the double-dabble converter.
    // The BCD digits sit in the upper bits; after the last shift they hold the
    // decimal value and stay put while the tokens are emitted.
    logic [snwt_pkg::SR_W-1:0] r_sr;
    logic [snwt_pkg::SR_W-1:0] sr_adj;

    // Output register; it decouples token generation from the sink.
    logic                          r_ov;
    logic [snwt_pkg::CLASS_W-1:0]  r_cls;
    logic [snwt_pkg::DIGIT_W-1:0]  r_dig;
    logic                          r_short;
    logic                          r_last;

    // Control from the output decoder.
    logic in_ready;
    logic conv_en;
    logic out_load;
    logic zero_load;
    logic step_adv;
    logic grp_adv;

    logic                          in_fire;
    logic [snwt_pkg::VALUE_W-1:0]  in_sat;
    logic                          slot_free;
    logic                          conv_done;
    logic                          walk_end;

    logic [3:0]                    dg_h, dg_t, dg_u;
    logic                          grp_zero;
    logic                          units_zero, thou_zero;
    snwt_pkg::t_group              final_grp;
    snwt_pkg::t_token              tok;
    snwt_pkg::t_token              vm_tok;
    logic [snwt_pkg::STEP_NUM-1:0] vmask;
    logic                          later_any;
    logic                          tok_last;

    assign in_fire   = i_in.valid && in_ready;
    assign in_sat    = (i_in.value > snwt_pkg::VALUE_MAX) ? snwt_pkg::VALUE_MAX : i_in.value;
    assign slot_free = !r_ov || o_out.ready;
    assign conv_done = (r_cnt == snwt_pkg::CNT_W'(snwt_pkg::VALUE_W - 1));

    // One double-dabble iteration: every BCD digit of five or more gets three added,
    // then the whole register shifts left by one bit.
    always_comb begin
        sr_adj = r_sr;
        for (int i = 0; i < snwt_pkg::BCD_DIGITS; i++) begin
            if (r_sr[snwt_pkg::VALUE_W + 4*i +: 4] >= 4'd5) begin
                sr_adj[snwt_pkg::VALUE_W + 4*i +: 4] = r_sr[snwt_pkg::VALUE_W + 4*i +: 4] + 4'd3;
            end
        end
    end

    // Digits of the group being walked.
    always_comb begin
        case (r_grp)
            snwt_pkg::G_MILL: begin
                dg_h = r_sr[snwt_pkg::VALUE_W + 32 +: 4];
                dg_t = r_sr[snwt_pkg::VALUE_W + 28 +: 4];
                dg_u = r_sr[snwt_pkg::VALUE_W + 24 +: 4];
            end
            snwt_pkg::G_THOU: begin
                dg_h = r_sr[snwt_pkg::VALUE_W + 20 +: 4];
                dg_t = r_sr[snwt_pkg::VALUE_W + 16 +: 4];
                dg_u = r_sr[snwt_pkg::VALUE_W + 12 +: 4];
            end
            default: begin
                dg_h = r_sr[snwt_pkg::VALUE_W + 8 +: 4];
                dg_t = r_sr[snwt_pkg::VALUE_W + 4 +: 4];
                dg_u = r_sr[snwt_pkg::VALUE_W +: 4];
            end
        endcase
    end

    assign grp_zero   = (dg_h == 4'd0) && (dg_t == 4'd0) && (dg_u == 4'd0);
    assign units_zero = (r_sr[snwt_pkg::VALUE_W +: 12] == 12'd0);
    assign thou_zero  = (r_sr[snwt_pkg::VALUE_W + 12 +: 12] == 12'd0);

    // The last token of the number belongs to the lowest nonzero group.
    always_comb begin
        if (!units_zero) begin
            final_grp = snwt_pkg::G_UNIT;
        end else if (!thou_zero) begin
            final_grp = snwt_pkg::G_THOU;
        end else begin
            final_grp = snwt_pkg::G_MILL;
        end
    end

    // Token of the current slot, and which slots of this group produce anything,
    // so that the last token can be flagged without looking ahead in time.
    assign tok = snwt_pkg::tok_at(r_step, r_grp, dg_h, dg_t, dg_u);

    always_comb begin
        vm_tok = '0;
        for (int s = 0; s < snwt_pkg::STEP_NUM; s++) begin
            vm_tok   = snwt_pkg::tok_at(snwt_pkg::t_step'(3'(s)), r_grp, dg_h, dg_t, dg_u);
            vmask[s] = vm_tok.valid;
        end
    end

    always_comb begin
        later_any = 1'b0;
        for (int s = 0; s < snwt_pkg::STEP_NUM; s++) begin
            if (3'(s) > r_step) begin
                later_any = later_any | vmask[s];
            end
        end
    end

    assign tok_last = (r_grp == final_grp) && !later_any;

    // The walk ends after the last slot of the units group, or when the units group
    // is empty and gets skipped as a whole.
    assign walk_end = (r_grp == snwt_pkg::G_UNIT) &&
                      (grp_zero || (r_step == snwt_pkg::STEP_SUF2 && step_adv));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            snwt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (in_sat == '0) ? snwt_pkg::ST_ZERO : snwt_pkg::ST_CONV;
                end
            end
            snwt_pkg::ST_CONV: begin
                if (conv_done) begin
                    n_state = snwt_pkg::ST_EMIT;
                end
            end
            snwt_pkg::ST_ZERO: begin
                if (slot_free) begin
                    n_state = snwt_pkg::ST_IDLE;
                end
            end
            snwt_pkg::ST_EMIT: begin
                if (walk_end) begin
                    n_state = snwt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = snwt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        in_ready  = 1'b0;
        conv_en   = 1'b0;
        out_load  = 1'b0;
        zero_load = 1'b0;
        step_adv  = 1'b0;
        grp_adv   = 1'b0;
        case (r_state)
            snwt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            snwt_pkg::ST_CONV: begin
                conv_en = 1'b1;
            end
            snwt_pkg::ST_ZERO: begin
                zero_load = slot_free;
            end
            snwt_pkg::ST_EMIT: begin
                if (grp_zero) begin
                    grp_adv = 1'b1;
                end else begin
                    // A slot with no word moves on at once; a word waits for room.
                    out_load = tok.valid && slot_free;
                    step_adv = !tok.valid || slot_free;
                    grp_adv  = step_adv && (r_step == snwt_pkg::STEP_SUF2);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= snwt_pkg::ST_IDLE;
            r_grp   <= snwt_pkg::G_MILL;
            r_step  <= snwt_pkg::STEP_HUND;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_grp  <= snwt_pkg::G_MILL;
                r_step <= snwt_pkg::STEP_HUND;
                r_cnt  <= '0;
            end else begin
                if (conv_en) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (grp_adv) begin
                    r_grp  <= snwt_pkg::t_group'(r_grp + 2'd1);
                    r_step <= snwt_pkg::STEP_HUND;
                end else if (step_adv) begin
                    r_step <= snwt_pkg::t_step'(r_step + 3'd1);
                end
            end
        end
    end

    // Converter datapath.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sr <= {{snwt_pkg::BCD_W{1'b0}}, in_sat};
        end else if (conv_en) begin
            r_sr <= {sr_adj[snwt_pkg::SR_W-2:0], 1'b0};
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load || zero_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (zero_load) begin
            r_cls   <= snwt_pkg::CL_CERO;
            r_dig   <= '0;
            r_short <= 1'b0;
            r_last  <= 1'b1;
        end else if (out_load) begin
            r_cls   <= tok.cls;
            r_dig   <= tok.dig;
            r_short <= tok.shortf;
            r_last  <= tok_last;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.word_class = r_cls;
    assign o_out.digit      = r_dig;
    assign o_out.short_form = r_short;
    assign o_out.last       = r_last;

endmodule

`default_nettype wire

/* tb/sv/tb_spanish_number_word_tokens_core.sv */
// Testbench for the Spanish number word token block: directed and random numbers checked token by token.
`default_nettype none

module tb_spanish_number_word_tokens_core;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct number has 14 tokens that may each wait out a receiver
    // stall; with about 480 numbers and sender gaps the run stays far below the
    // limit chosen here.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles allowed after the last token before the verdict is printed.
    localparam int DRAIN_CYCLES = 60;

    // One expected word token, in the field layout of the output interface.
    typedef struct packed {
        logic [snwt_pkg::CLASS_W-1:0] cls;
        logic [snwt_pkg::DIGIT_W-1:0] dig;
        logic                         shortf;
        logic                         last;
    } t_word;

    logic i_clk;
    logic i_rst_n;

    snwt_in_if  num_ch ();
    snwt_out_if word_ch ();

    spanish_number_word_tokens_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (word_ch)
    );

    // Words still owed by the block, oldest first, and the scratch list that
    // the speller fills for one number before it is appended there.
    t_word words_due[$];
    t_word spelled[$];

    int  bad_words;
    int  cycle_count;
    int  stall_left;
    // When clear, neither the number sender nor the token receiver pauses.
    bit  idle_on;

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Speller: the expected token stream of one number.
    // ------------------------------------------------------------------

    function automatic void add_word(logic [snwt_pkg::CLASS_W-1:0] cls,
                                     logic [snwt_pkg::DIGIT_W-1:0] dig, logic shortf);
        t_word w;
        w.cls    = cls;
        w.dig    = dig;
        w.shortf = shortf;
        w.last   = 1'b0;
        spelled.push_back(w);
    endfunction

    // A trailing one in front of mil or millon turns into un, and a whole group
    // of one says nothing, since its suffix carries it.
    function automatic void add_unit(int unsigned unit_dig, int unsigned grp, bit suffix);
        if (unit_dig == 1 && suffix) begin
            if (grp != 1) begin
                add_word(snwt_pkg::CL_UN, 4'd1, 1'b1);
            end
        end else begin
            add_word(snwt_pkg::CL_UNIT, 4'(unit_dig), 1'b0);
        end
    endfunction

    // Spells one three-digit group in 1..999.
    function automatic void spell_group(int unsigned grp, bit suffix);
        int unsigned hun;
        int unsigned rest;
        int unsigned ten;
        int unsigned one;
        hun  = grp / 100;
        rest = grp % 100;
        ten  = rest / 10;
        one  = rest % 10;

        // Cien stands alone only for an exact hundred; otherwise ciento.
        if (hun == 1) begin
            add_word((rest == 0) ? snwt_pkg::CL_CIEN : snwt_pkg::CL_CIENTO, 4'd0, 1'b0);
        end else if (hun > 1) begin
            add_word(snwt_pkg::CL_HUNDREDS, 4'(hun), 1'b0);
        end

        if (rest != 0) begin
            if (ten == 0) begin
                add_unit(one, grp, suffix);
            end else if (one == 0) begin
                add_word(snwt_pkg::CL_TENS, 4'(ten), 1'b0);
            end else if (ten == 1) begin
                // Once to quince are words of their own; dieciseis up are compounds.
                add_word((one > 5) ? snwt_pkg::CL_DIECI : snwt_pkg::CL_TEEN, 4'(one), 1'b0);
            end else if (ten == 2) begin
                add_word(snwt_pkg::CL_VEINTI, 4'(one), (one == 1) && suffix);
            end else begin
                add_word(snwt_pkg::CL_TENS, 4'(ten), 1'b0);
                add_word(snwt_pkg::CL_Y, 4'd0, 1'b0);
                add_unit(one, grp, suffix);
            end
        end
    endfunction

    // Appends the tokens of one accepted number to the words owed.
    function automatic void spell_number(logic [snwt_pkg::VALUE_W-1:0] raw);
        int unsigned v;
        int unsigned mil_grp;
        int unsigned thou_grp;
        int unsigned unit_grp;
        t_word       w;
        v = raw;
        // Numbers beyond nine digits saturate to the largest one.
        if (raw > snwt_pkg::VALUE_MAX) begin
            v = snwt_pkg::VALUE_MAX;
        end
        spelled.delete();

        if (v == 0) begin
            add_word(snwt_pkg::CL_CERO, 4'd0, 1'b0);
        end else begin
            mil_grp  = v / 1000000;
            thou_grp = (v / 1000) % 1000;
            unit_grp = v % 1000;
            if (mil_grp != 0) begin
                spell_group(mil_grp, 1'b1);
                if (mil_grp == 1) begin
                    add_word(snwt_pkg::CL_UN, 4'd1, 1'b1);
                    add_word(snwt_pkg::CL_MILLON, 4'd0, 1'b0);
                end else begin
                    add_word(snwt_pkg::CL_MILLONES, 4'd0, 1'b0);
                end
            end
            if (thou_grp != 0) begin
                spell_group(thou_grp, 1'b1);
                add_word(snwt_pkg::CL_MIL, 4'd0, 1'b0);
            end
            if (unit_grp != 0) begin
                spell_group(unit_grp, 1'b0);
            end
        end

        foreach (spelled[i]) begin
            w      = spelled[i];
            w.last = (i == spelled.size() - 1);
            words_due.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, a number beat adds its words to the
    // list owed, and a token beat is checked against the oldest one. The
    // number is handled first so the list never runs dry on a same-edge pair.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d tokens still owed",
                     $realtime, CYCLE_LIMIT, words_due.size());
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (num_ch.valid && num_ch.ready) begin
                spell_number(num_ch.value);
            end
            if (word_ch.valid && word_ch.ready) begin
                got.cls    = word_ch.word_class;
                got.dig    = word_ch.digit;
                got.shortf = word_ch.short_form;
                got.last   = word_ch.last;
                if (words_due.size() == 0) begin
                    bad_words = bad_words + 1;
                    $display("%0t: token beat with none owed: expected nothing, actual ",
                             $realtime, "class=%0d digit=%0d short=%0b last=%0b",
                             got.cls, got.dig, got.shortf, got.last);
                end else begin
                    want = words_due.pop_front();
                    if (got.cls !== want.cls || got.dig !== want.dig ||
                        got.shortf !== want.shortf || got.last !== want.last) begin
                        bad_words = bad_words + 1;
                        $display("%0t: token mismatch: expected class=%0d digit=%0d",
                                 $realtime, want.cls, want.dig,
                                 " short=%0b last=%0b, actual class=%0d",
                                 want.shortf, want.last, got.cls,
                                 " digit=%0d short=%0b last=%0b",
                                 got.dig, got.shortf, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Token receiver: ready drops in random bursts while idling is on,
    // and stays high otherwise. It changes on the falling edge only.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            word_ch.ready = 1'b0;
            stall_left    = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            word_ch.ready = 1'b0;
            stall_left    = $urandom_range(0, 2);
        end else begin
            word_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Number sender. It is entered on a falling edge and returns on the
    // falling edge after the beat, so valid stays high between back-to-back
    // numbers and is only lowered for a gap.
    // ------------------------------------------------------------------

    task automatic send_number(input logic [snwt_pkg::VALUE_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            num_ch.valid = 1'b0;
            gap          = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        num_ch.valid = 1'b1;
        num_ch.value = v;
        @(posedge i_clk);
        while (!num_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // A three-digit group drawn so that ones, teens, twenties, exact hundreds
    // and empty groups come up far more often than a flat draw would give.
    function automatic int unsigned pick_group();
        int unsigned grp;
        case ($urandom_range(0, 7))
            0: grp = 0;
            1: grp = 1;
            2: grp = $urandom_range(10, 29);
            3: grp = 100 * $urandom_range(1, 9);
            4: grp = 100 * $urandom_range(0, 9) + $urandom_range(0, 9);
            5: grp = 100 * $urandom_range(0, 9) + 10 * $urandom_range(2, 9) + 1;
            default: grp = $urandom_range(0, 999);
        endcase
        return grp;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Zero, one, the largest number and inputs above range, which saturate.
    task automatic test_range_edges();
        send_number(30'd0);
        send_number(30'd1);
        send_number(30'd999999999);
        send_number(30'd1000000000);
        send_number(30'h3FFF_FFFF);
    endtask

    // Suffix handling: a group of one, un before mil and millon, and
    // veintiun and treinta y un before a suffix.
    task automatic test_group_suffixes();
        send_number(30'd1000000);
        send_number(30'd1000);
        send_number(30'd1001001);
        send_number(30'd21000);
        send_number(30'd21000000);
        send_number(30'd31001);
        send_number(30'd1031000);
        send_number(30'd2000000);
    endtask

    // Hundreds, including the irregular ones, and the tens and teen forms.
    task automatic test_group_words();
        send_number(30'd100);
        send_number(30'd101);
        send_number(30'd500);
        send_number(30'd700);
        send_number(30'd900);
        send_number(30'd115);
        send_number(30'd116);
        send_number(30'd10);
        send_number(30'd20);
        send_number(30'd99);
        send_number(30'd200000201);
    endtask

    // Random numbers in chunks; each chunk decides whether both sides idle,
    // so quiet stretches alternate with bursty ones.
    task automatic test_random_numbers(input int count);
        int unsigned v;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                // A flat draw over the whole 30-bit field, a small share of it above range.
                0: v = $urandom_range(0, 32'h3FFF_FFFF);
                1: v = $urandom_range(0, 999999999);
                2: v = $urandom_range(0, 999);
                default: v = pick_group() * 1000000 + pick_group() * 1000 + pick_group();
            endcase
            send_number(30'(v));
        end
    endtask

    // The closing stretch runs with both sides at full rate.
    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_number(30'(pick_group() * 1000000 + pick_group() * 1000 + pick_group()));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.value  = '0;
        word_ch.ready = 1'b1;
        bad_words     = 0;
        cycle_count   = 0;
        stall_left    = 0;
        idle_on       = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_on = 1'b1;
        test_range_edges();
        test_group_suffixes();
        test_group_words();
        test_random_numbers(400);
        test_full_rate(50);
        num_ch.valid = 1'b0;

        // Let every owed token arrive, then give the block time to show any
        // token that nobody asked for.
        while (words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_words == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
